// File: rtl/rbi_pkg.sv
// Shared widths, codes and the multiplier control word for the planar rigid-body integrator.
// No dependencies; every other rtl file imports this package.
package rbi_pkg;

   localparam int FRAC_DEFAULT = 16;
   localparam int ANGLE_FRAC   = 28;
   localparam int SUM_W        = 40;
   localparam int POS_W        = 48;
   localparam int VEL_W        = 32;
   localparam int ACC_W        = 48;
   localparam int TERM_W       = 62;
   localparam int DTH_W        = 41;
   localparam int HEAD_W       = 31;
   localparam int MA_W         = 62;
   localparam int MB_W         = 32;
   localparam int PROD_W       = MA_W + MB_W;
   localparam int WX_W         = 64;
   localparam int CSR_IDX_W    = 3;

   localparam logic [HEAD_W-1:0] TWO_PI_Q28 = 31'd1686629713;

   localparam logic [1:0] REQ_FORCE  = 2'd0;
   localparam logic [1:0] REQ_TORQUE = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;
   // undefined request kind, ignored by the block
   localparam logic [1:0] REQ_NONE   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_INV_MASS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_INERTIA = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PPM         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_X     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Y     = 3'd4;
   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_NONE        = 3'd7;

   typedef enum logic [1:0] {
      SHIFT_16,
      SHIFT_17,
      SHIFT_24
   } shift_sel_type;

   typedef struct packed {
      logic          start;
      shift_sel_type shift;
      logic          sat_wide;
   } mul_ctl_type;

endpackage

// File: rtl/rbi_mul.sv
// Bit-serial signed-by-unsigned multiplier with floored scaling and saturation.
// One multiplier bit per cycle, then a final step that scales and clamps. Depends on rbi_pkg.
module rbi_mul (
   input  logic                               clock,
   input  logic                               reset,
   input  rbi_pkg::mul_ctl_type               ctl,
   input  logic signed [rbi_pkg::MA_W-1:0]    op_a,
   input  logic        [rbi_pkg::MB_W-1:0]    op_b,
   output logic                               done,
   output logic signed [rbi_pkg::TERM_W-1:0]  result
);
   import rbi_pkg::*;

   localparam int CNT_W = $clog2(MB_W);
   localparam int Q_W   = PROD_W - 16 + 1;

   logic                     neg_ff;
   logic [MA_W-1:0]          mag_ff;
   logic [MB_W-1:0]          mult_ff;
   logic [MA_W-1:0]          acc_ff;
   logic [MB_W-1:0]          lo_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic                     busy_ff;
   logic                     fin_ff;
   logic                     done_ff;
   shift_sel_type            shift_ff;
   logic                     wide_ff;
   logic signed [TERM_W-1:0] result_ff;

   logic [MA_W:0]     step_sum;
   logic [PROD_W-1:0] prod;
   logic [Q_W-1:0]    quo;
   logic [Q_W-1:0]    quo_adj;
   logic              sticky;
   logic [Q_W-1:0]    lim;
   logic [Q_W-1:0]    fin_val;

   assign step_sum = {1'b0, acc_ff} + (mult_ff[0] ? {1'b0, mag_ff} : '0);
   assign prod     = {acc_ff, lo_ff};

   always_comb begin
      unique case (shift_ff)
         SHIFT_16: begin
            quo    = Q_W'(prod >> 16);
            sticky = |lo_ff[15:0];
         end
         SHIFT_17: begin
            quo    = Q_W'(prod >> 17);
            sticky = |lo_ff[16:0];
         end
         SHIFT_24: begin
            quo    = Q_W'(prod >> 24);
            sticky = |lo_ff[23:0];
         end
         default: begin
            quo    = Q_W'(prod >> 16);
            sticky = |lo_ff[15:0];
         end
      endcase
      // negative products round toward minus infinity
      quo_adj = quo + Q_W'(neg_ff & sticky);
      lim = wide_ff ? (Q_W'(1) << (TERM_W - 1)) - Q_W'(1)
                    : (Q_W'(1) << (ACC_W - 1)) - Q_W'(1);
      if (neg_ff) begin
         fin_val = (quo_adj > lim + Q_W'(1)) ? -(lim + Q_W'(1)) : -quo_adj;
      end else begin
         fin_val = (quo_adj > lim) ? lim : quo_adj;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            neg_ff   <= op_a[MA_W-1];
            mag_ff   <= op_a[MA_W-1] ? MA_W'(-op_a) : MA_W'(op_a);
            mult_ff  <= op_b;
            acc_ff   <= '0;
            lo_ff    <= '0;
            cnt_ff   <= '0;
            shift_ff <= ctl.shift;
            wide_ff  <= ctl.sat_wide;
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            acc_ff  <= step_sum[MA_W:1];
            lo_ff   <= {step_sum[0], lo_ff[MB_W-1:1]};
            mult_ff <= mult_ff >> 1;
            cnt_ff  <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MB_W - 1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            result_ff <= fin_val[TERM_W-1:0];
            fin_ff    <= 1'b0;
            done_ff   <= 1'b1;
         end
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// File: rtl/rbi_wrap.sv
// Angle wrap unit: restoring reduction modulo 2*pi, one quotient bit per cycle,
// then a fold into [-pi, pi]. Depends on rbi_pkg.
module rbi_wrap (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [rbi_pkg::WX_W-1:0]    angle_sum,
   output logic                               done,
   output logic signed [rbi_pkg::HEAD_W-1:0]  heading
);
   import rbi_pkg::*;

   localparam int STEPS = WX_W - HEAD_W + 1;
   localparam int CNT_W = $clog2(STEPS);
   localparam logic [WX_W-1:0] DIV_INIT = {TWO_PI_Q28, {(WX_W - HEAD_W){1'b0}}};
   localparam logic signed [HEAD_W:0] C_EXT = {1'b0, TWO_PI_Q28};
   localparam logic signed [HEAD_W:0] HALF_C = (C_EXT - 1) / 2;

   logic [WX_W-1:0]          mag_ff;
   logic [WX_W-1:0]          div_ff;
   logic                     neg_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic                     busy_ff;
   logic                     fin_ff;
   logic                     done_ff;
   logic signed [HEAD_W-1:0] heading_ff;

   logic signed [HEAD_W:0] rem;
   logic signed [HEAD_W:0] pos_rem;
   logic signed [HEAD_W:0] folded;

   always_comb begin
      rem     = {1'b0, mag_ff[HEAD_W-1:0]};
      pos_rem = (neg_ff && rem != '0) ? C_EXT - rem : rem;
      folded  = (pos_rem > HALF_C) ? pos_rem - C_EXT : pos_rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            neg_ff  <= angle_sum[WX_W-1];
            mag_ff  <= angle_sum[WX_W-1] ? WX_W'(-angle_sum) : WX_W'(angle_sum);
            div_ff  <= DIV_INIT;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (mag_ff >= div_ff) begin
               mag_ff <= mag_ff - div_ff;
            end
            div_ff <= div_ff >> 1;
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            heading_ff <= folded[HEAD_W-1:0];
            fin_ff     <= 1'b0;
            done_ff    <= 1'b1;
         end
      end
   end

   assign done    = done_ff;
   assign heading = heading_ff;

endmodule

// File: rtl/rigid_body_2d_integrator.sv
// Planar rigid-body integrator: top level with sequencer, state and the register port.
// Depends on rbi_pkg, rbi_mul and rbi_wrap.
//
// Force and torque words are summed into their accumulators and give no result. A tick word
// runs fourteen products through one bit-serial multiplier (each takes the multiplier bits,
// a scale-and-clamp step, issue and hand-back), x axis, y axis, then rotation, followed by
// the serial angle wrap. The multiplier is the pacing unit. New words are taken only while
// the sequencer is idle; a finished result waits in its output register. Register writes
// are taken in any cycle and must only be issued while the block is idle.
module rigid_body_2d_integrator #(
   parameter int FRACTION_BITS = rbi_pkg::FRAC_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic        [1:0]                    req_type,
   input  logic signed [31:0]                   req_force_x,
   input  logic signed [31:0]                   req_force_y,
   input  logic signed [31:0]                   req_torque,
   input  logic        [15:0]                   req_time_step,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [31:0]                   rsp_pixel_x,
   output logic signed [31:0]                   rsp_pixel_y,
   output logic signed [31:0]                   rsp_velocity_x,
   output logic signed [31:0]                   rsp_velocity_y,
   output logic signed [rbi_pkg::HEAD_W-1:0]    rsp_heading,
   output logic signed [31:0]                   rsp_spin_rate,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic        [rbi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [31:0]                   csr_wdata
);
   import rbi_pkg::*;

   localparam int ASH = ANGLE_FRAC - FRACTION_BITS;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ISSUE, ST_WAIT, ST_WRAP_GO, ST_WRAP_WAIT, ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      STEP_ACC, STEP_DV, STEP_VT, STEP_HALF, STEP_PIX
   } step_type;

   typedef enum logic [1:0] {
      AXIS_X, AXIS_Y, AXIS_ROT
   } axis_type;

   function automatic logic signed [63:0] sat(input logic signed [63:0] v, input int w);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (w - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   state_type state_ff;
   step_type  step_ff;
   axis_type  axis_ff;

   logic        [31:0]        inv_mass_ff;
   logic        [31:0]        inv_inertia_ff;
   logic        [31:0]        ppm_ff;
   logic signed [SUM_W-1:0]   fsx_ff;
   logic signed [SUM_W-1:0]   fsy_ff;
   logic signed [SUM_W-1:0]   tsum_ff;
   logic signed [POS_W-1:0]   posx_ff;
   logic signed [POS_W-1:0]   posy_ff;
   logic signed [VEL_W-1:0]   velx_ff;
   logic signed [VEL_W-1:0]   vely_ff;
   logic signed [VEL_W-1:0]   angle_ff;
   logic signed [VEL_W-1:0]   angvel_ff;
   logic        [15:0]        dt_ff;
   logic signed [TERM_W-1:0]  dv_ff;
   logic signed [TERM_W-1:0]  t_ff;
   logic signed [DTH_W-1:0]   dth_ff;
   logic                      rsp_valid_ff;
   logic signed [31:0]        pix_x_ff;
   logic signed [31:0]        pix_y_ff;
   logic signed [31:0]        out_vx_ff;
   logic signed [31:0]        out_vy_ff;
   logic signed [HEAD_W-1:0]  out_head_ff;
   logic signed [31:0]        out_w_ff;

   mul_ctl_type              mul_ctl;
   logic signed [MA_W-1:0]   mul_a;
   logic        [MB_W-1:0]   mul_b;
   logic                     mul_done;
   logic signed [TERM_W-1:0] mul_result;
   logic                     wrap_start;
   logic signed [WX_W-1:0]   wrap_in;
   logic                     wrap_done;
   logic signed [HEAD_W-1:0] wrap_angle;

   logic signed [SUM_W-1:0]  sum_sel;
   logic signed [VEL_W-1:0]  vel_sel;
   logic signed [63:0]       start_load;
   logic signed [63:0]       half_sum;
   logic signed [63:0]       vel_new;
   logic signed [63:0]       pix_x_full;
   logic signed [63:0]       pix_y_full;

   always_comb begin
      unique case (axis_ff)
         AXIS_X: begin
            sum_sel = fsx_ff;
            vel_sel = velx_ff;
         end
         AXIS_Y: begin
            sum_sel = fsy_ff;
            vel_sel = vely_ff;
         end
         AXIS_ROT: begin
            sum_sel = tsum_ff;
            vel_sel = angvel_ff;
         end
         default: begin
            sum_sel = tsum_ff;
            vel_sel = angvel_ff;
         end
      endcase

      mul_ctl.start    = (state_ff == ST_ISSUE);
      mul_ctl.shift    = SHIFT_16;
      mul_ctl.sat_wide = 1'b1;
      mul_a            = dv_ff;
      mul_b            = MB_W'(dt_ff);
      unique case (step_ff)
         STEP_ACC: begin
            mul_a            = MA_W'(sum_sel);
            mul_b            = (axis_ff == AXIS_ROT) ? inv_inertia_ff : inv_mass_ff;
            mul_ctl.shift    = SHIFT_24;
            mul_ctl.sat_wide = 1'b0;
         end
         STEP_DV: begin
            mul_a = dv_ff;
         end
         STEP_VT: begin
            mul_a = MA_W'(vel_sel);
         end
         STEP_HALF: begin
            mul_a         = dv_ff;
            mul_ctl.shift = SHIFT_17;
         end
         STEP_PIX: begin
            mul_a = t_ff;
            mul_b = ppm_ff;
         end
         default: begin
            mul_a = dv_ff;
         end
      endcase

      start_load = sat(64'($signed(csr_wdata)) <<< FRACTION_BITS, POS_W);
      half_sum   = 64'(t_ff) + 64'(mul_result);
      vel_new    = sat(64'(vel_sel) + 64'(dv_ff), VEL_W);
      wrap_start = (state_ff == ST_WRAP_GO);
      wrap_in    = 64'(angle_ff) + (64'(dth_ff) <<< ASH);
      pix_x_full = sat(64'(posx_ff >>> FRACTION_BITS), 32);
      pix_y_full = sat(64'(posy_ff >>> FRACTION_BITS), 32);
   end

   rbi_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mul_ctl),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_result)
   );

   rbi_wrap u_wrap (
      .clock     (clock),
      .reset     (reset),
      .start     (wrap_start),
      .angle_sum (wrap_in),
      .done      (wrap_done),
      .heading   (wrap_angle)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= STEP_ACC;
         axis_ff        <= AXIS_X;
         rsp_valid_ff   <= 1'b0;
         inv_mass_ff    <= 32'd16777;
         inv_inertia_ff <= 32'd16777;
         ppm_ff         <= 32'd655360;
         fsx_ff         <= '0;
         fsy_ff         <= '0;
         tsum_ff        <= '0;
         posx_ff        <= '0;
         posy_ff        <= '0;
         velx_ff        <= '0;
         vely_ff        <= '0;
         angle_ff       <= '0;
         angvel_ff      <= '0;
      end else begin
         // in the output state the valid flag is reloaded below
         if (rsp_valid_ff && rsp_ready && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_valid) begin
            unique case (csr_index)
               CSR_INV_MASS:    inv_mass_ff    <= csr_wdata;
               CSR_INV_INERTIA: inv_inertia_ff <= csr_wdata;
               CSR_PPM:         ppm_ff         <= csr_wdata;
               CSR_START_X:     posx_ff        <= start_load[POS_W-1:0];
               CSR_START_Y:     posy_ff        <= start_load[POS_W-1:0];
               default: ;
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  if (req_type == REQ_FORCE) begin
                     fsx_ff <= SUM_W'(sat(64'(fsx_ff) + 64'(req_force_x), SUM_W));
                     fsy_ff <= SUM_W'(sat(64'(fsy_ff) + 64'(req_force_y), SUM_W));
                  end else if (req_type == REQ_TORQUE) begin
                     tsum_ff <= SUM_W'(sat(64'(tsum_ff) + 64'(req_torque), SUM_W));
                  end else if (req_type == REQ_TICK) begin
                     dt_ff    <= req_time_step;
                     axis_ff  <= AXIS_X;
                     step_ff  <= STEP_ACC;
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            ST_ISSUE: begin
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (mul_done) begin
                  state_ff <= ST_ISSUE;
                  unique case (step_ff)
                     STEP_ACC: begin
                        dv_ff   <= mul_result;
                        step_ff <= STEP_DV;
                     end
                     STEP_DV: begin
                        dv_ff   <= mul_result;
                        step_ff <= STEP_VT;
                     end
                     STEP_VT: begin
                        t_ff    <= mul_result;
                        step_ff <= STEP_HALF;
                     end
                     STEP_HALF: begin
                        // velocity terms above used the old rate, so update it now
                        if (axis_ff == AXIS_ROT) begin
                           dth_ff    <= DTH_W'(sat(half_sum, DTH_W));
                           angvel_ff <= vel_new[VEL_W-1:0];
                           state_ff  <= ST_WRAP_GO;
                        end else begin
                           t_ff    <= TERM_W'(sat(half_sum, TERM_W));
                           step_ff <= STEP_PIX;
                           if (axis_ff == AXIS_X) begin
                              velx_ff <= vel_new[VEL_W-1:0];
                           end else begin
                              vely_ff <= vel_new[VEL_W-1:0];
                           end
                        end
                     end
                     STEP_PIX: begin
                        // screen y grows downward
                        if (axis_ff == AXIS_X) begin
                           posx_ff <= POS_W'(sat(64'(posx_ff) + 64'(mul_result), POS_W));
                           axis_ff <= AXIS_Y;
                        end else begin
                           posy_ff <= POS_W'(sat(64'(posy_ff) - 64'(mul_result), POS_W));
                           axis_ff <= AXIS_ROT;
                        end
                        step_ff <= STEP_ACC;
                     end
                     default: begin
                        step_ff <= STEP_ACC;
                     end
                  endcase
               end
            end
            ST_WRAP_GO: begin
               state_ff <= ST_WRAP_WAIT;
            end
            ST_WRAP_WAIT: begin
               if (wrap_done) begin
                  angle_ff <= VEL_W'(wrap_angle);
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  pix_x_ff     <= pix_x_full[31:0];
                  pix_y_ff     <= pix_y_full[31:0];
                  out_vx_ff    <= velx_ff;
                  out_vy_ff    <= vely_ff;
                  out_head_ff  <= angle_ff[HEAD_W-1:0];
                  out_w_ff     <= angvel_ff;
                  rsp_valid_ff <= 1'b1;
                  fsx_ff       <= '0;
                  fsy_ff       <= '0;
                  tsum_ff      <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_x    = pix_x_ff;
   assign rsp_pixel_y    = pix_y_ff;
   assign rsp_velocity_x = out_vx_ff;
   assign rsp_velocity_y = out_vy_ff;
   assign rsp_heading    = out_head_ff;
   assign rsp_spin_rate  = out_w_ff;

   a_mul_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_WAIT)
      else $error("multiplier finished outside its wait state");

   a_wrap_in_range: assert property (@(posedge clock) disable iff (reset)
      wrap_done |-> (wrap_angle <= 31'sd843314856 && wrap_angle >= -31'sd843314856))
      else $error("wrapped angle outside minus pi to pi");

   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == ST_OUT && state_ff == ST_IDLE)
         |-> (fsx_ff == '0 && fsy_ff == '0 && tsum_ff == '0))
      else $error("force or torque sum not cleared after a tick");

endmodule
